### hdl/tpse_pkg.sv
// shared constants and types of the tooth period speed estimator
`timescale 1ns / 1ps

package tpse_pkg;

  localparam int PERIOD_CAP     = 500000;
  localparam int PERIOD_FLOOR   = 1000;
  localparam int SPEED_DIVIDEND = 1000000;
  localparam int SPEED_FLOOR    = -500;
  localparam int SPEED_CEIL     = 1000;
  localparam int MIN_PERIODS    = 2;

  // capped period fits 19 bits, quotient of dividend by floored period fits 10 bits
  localparam int PER_W  = 19;
  localparam int QUOT_W = 10;
  localparam int SPD_W  = 11;
  localparam int CNT_W  = $clog2(QUOT_W);

  // upper dividend bits stay below the period floor, so their quotient bits are zero
  localparam logic [PER_W-1:0]  DIV_PRELOAD = PER_W'(SPEED_DIVIDEND >> QUOT_W);
  localparam logic [QUOT_W-1:0] DIV_LOW     = QUOT_W'(SPEED_DIVIDEND);

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

endpackage

### hdl/tpse_div.sv
// bit-serial restoring divider: fixed speed dividend over the tooth period
`timescale 1ns / 1ps

module tpse_div
  import tpse_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [PER_W-1:0] divisor_i,
  output div_res_t         res_o
);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PER_W-1:0]  rem_q;
  logic [PER_W-1:0]  dsr_q;
  logic [QUOT_W-1:0] dvd_q;
  logic [QUOT_W-1:0] quot_q;

  logic [PER_W:0]   trial;
  logic             fits;
  logic [PER_W-1:0] rem_d;

  // shift in one dividend bit, trial subtract
  assign trial = {rem_q, dvd_q[QUOT_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};
  assign rem_d = fits ? PER_W'(trial - {1'b0, dsr_q}) : trial[PER_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // done pulses for one cycle after the last quotient bit
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(QUOT_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUOT_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= DIV_PRELOAD;
      dsr_q  <= divisor_i;
      dvd_q  <= DIV_LOW;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dvd_q  <= {dvd_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], fits};
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;

endmodule

### hdl/tooth_period_speed_estimator.sv
// top level of the tooth period speed estimator
`timescale 1ns / 1ps

// usage
// - input channel in_valid_i / in_stall_o carries one beat per tooth event: fill counts,
//   status flags, raw speed, low-speed threshold, two tooth periods and direction
// - output channel out_valid_o / out_stall_i returns one beat per input beat, in order
// - cfg_we_i writes cfg_wdata_i into the phase fill threshold; write only while idle
// - an input beat is taken only in idle; in_stall_o stays high while one beat is in work
// - an accepted beat passes through the setup state, the divider over 10 quotient bits,
//   the state that sees the divider done and the final state that loads the output;
//   the next beat is taken only back in idle; the bit-serial divider produces one
//   quotient bit per cycle
// - the output register holds a finished beat while the receiver stalls; the next beat
//   can be accepted meanwhile, and its result waits in the final state until the
//   output register frees up
// - reset clears the validity latch, the threshold, the state and out_valid_o
module tooth_period_speed_estimator
  import tpse_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [7:0]              cfg_wdata_i,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              tooth_fill_count_i,
  input  logic [7:0]              time_fill_count_i,
  input  logic                    calc_enable_i,
  input  logic                    last_period_valid_i,
  input  logic                    first_calc_i,
  input  logic signed [15:0]      raw_speed_i,
  input  logic signed [15:0]      low_speed_threshold_i,
  input  logic [31:0]             latest_period_i,
  input  logic [31:0]             previous_period_i,
  input  logic                    forward_rotation_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SPD_W-1:0] period_speed_o,
  output logic                    cell_valid_o,
  output logic signed [SPD_W-1:0] corrected_speed_o,
  output logic                    corrected_valid_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_CALC,
    ST_FIN
  } state_e;

  state_e state_q;

  logic [7:0] phase_thr_q;
  logic       latch_q;

  // per-beat working registers
  logic [PER_W-1:0]       p_new_q;
  logic [PER_W-1:0]       p_old_q;
  logic signed [SPD_W-1:0] raw_cl_q;
  logic                   fwd_q;
  logic                   cell_q;
  logic                   enough_q;

  // output register
  logic                   out_valid_q;
  logic signed [SPD_W-1:0] pspeed_q;
  logic                   cell_out_q;
  logic signed [SPD_W-1:0] corr_q;
  logic                   corr_valid_q;

  logic                    in_acc;
  logic                    out_free;
  logic                    qualified;
  logic                    below_thr;
  logic [PER_W-1:0]        p_new_d;
  logic [PER_W-1:0]        p_old_d;
  logic signed [SPD_W-1:0] raw_cl_d;
  logic [PER_W-1:0]        pmin;
  logic [PER_W-1:0]        divisor;
  logic                    div_start;
  div_res_t                div_res;
  logic signed [SPD_W-1:0] pspeed_d;
  logic signed [SPD_W-1:0] corr_d;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // raw speed qualification and latch clear condition
  assign qualified = (tooth_fill_count_i > phase_thr_q) && calc_enable_i
                     && last_period_valid_i && !first_calc_i;
  assign below_thr = raw_speed_i < low_speed_threshold_i;

  // periods capped at accept
  assign p_new_d = (latest_period_i > 32'(PERIOD_CAP)) ? PER_W'(PERIOD_CAP)
                                                       : latest_period_i[PER_W-1:0];
  assign p_old_d = (previous_period_i > 32'(PERIOD_CAP)) ? PER_W'(PERIOD_CAP)
                                                         : previous_period_i[PER_W-1:0];

  // raw speed saturated to the output range
  always_comb begin
    if (int'(raw_speed_i) < SPEED_FLOOR) begin
      raw_cl_d = SPD_W'(SPEED_FLOOR);
    end else if (int'(raw_speed_i) > SPEED_CEIL) begin
      raw_cl_d = SPD_W'(SPEED_CEIL);
    end else begin
      raw_cl_d = raw_speed_i[SPD_W-1:0];
    end
  end

  // smaller period, floored, is the divisor
  assign pmin      = (p_new_q < p_old_q) ? p_new_q : p_old_q;
  assign divisor   = (pmin < PER_W'(PERIOD_FLOOR)) ? PER_W'(PERIOD_FLOOR) : pmin;
  assign div_start = (state_q == ST_PREP);

  tpse_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (divisor),
    .res_o     (div_res)
  );

  // sign by direction, floor for reverse rotation
  always_comb begin
    if (fwd_q) begin
      pspeed_d = SPD_W'({1'b0, div_res.quot});
    end else if (div_res.quot > QUOT_W'(-SPEED_FLOOR)) begin
      pspeed_d = SPD_W'(SPEED_FLOOR);
    end else begin
      pspeed_d = SPD_W'(0) - SPD_W'({1'b0, div_res.quot});
    end
  end

  // period speed already lies inside the clamp range
  always_comb begin
    if (cell_q) begin
      corr_d = raw_cl_q;
    end else if (enough_q) begin
      corr_d = pspeed_d;
    end else begin
      corr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_thr_q <= '0;
      latch_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        phase_thr_q <= cfg_wdata_i;
      end
      // load a finished beat, else drop the one the receiver took
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            // clearing wins over setting
            if (qualified && below_thr) begin
              latch_q <= 1'b0;
            end else if (first_calc_i) begin
              latch_q <= 1'b1;
            end
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_q <= ST_CALC;
        end
        ST_CALC: begin
          if (div_res.done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_new_q  <= p_new_d;
      p_old_q  <= p_old_d;
      raw_cl_q <= raw_cl_d;
      fwd_q    <= forward_rotation_i;
      // latch is unchanged for a qualified beat unless it clears
      cell_q   <= qualified && !below_thr && latch_q;
      enough_q <= time_fill_count_i >= 8'(MIN_PERIODS);
    end
    if (state_q == ST_FIN && out_free) begin
      pspeed_q     <= pspeed_d;
      cell_out_q   <= cell_q;
      corr_q       <= corr_d;
      corr_valid_q <= cell_q || enough_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign period_speed_o    = pspeed_q;
  assign cell_valid_o      = cell_out_q;
  assign corrected_speed_o = corr_q;
  assign corrected_valid_o = corr_valid_q;

  // an accepted beat keeps the input side stalled for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a valid cell always makes the corrected speed valid
  a_cell_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cell_valid_o |-> corrected_valid_o)
    else $error("cell valid without corrected valid");

  // an invalid corrected speed is zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !corrected_valid_o |-> corrected_speed_o == '0)
    else $error("invalid corrected speed not zero");

  // period speed stays inside its range
  a_pspeed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(period_speed_o) >= SPEED_FLOOR)
                    && (int'(period_speed_o) <= SPEED_CEIL))
    else $error("period speed out of range");

endmodule

### sim/tooth_period_speed_estimator_tb.sv
// self-checking testbench of the tooth period speed estimator
`timescale 1ns / 1ps

module tooth_period_speed_estimator_tb;
  import tpse_pkg::*;

  // one tooth event beat as the feeder offers it
  typedef struct {
    logic [7:0]        tooth_fill;
    logic [7:0]        time_fill;
    logic              calc_en;
    logic              period_ok;
    logic              first;
    logic signed [15:0] raw;
    logic signed [15:0] low_thd;
    logic [31:0]       p_latest;
    logic [31:0]       p_prev;
    logic              fwd;
  } tooth_beat_t;

  // one speed beat as the block returns it
  typedef struct {
    logic signed [SPD_W-1:0] period_speed;
    logic                    cell_valid;
    logic signed [SPD_W-1:0] corrected_speed;
    logic                    corrected_valid;
  } speed_beat_t;

  // directed row: typed marks a hand-written expectation
  typedef struct {
    tooth_beat_t beat;
    logic        typed;
    speed_beat_t want;
  } dir_row_t;

  localparam int PHASES       = 6;
  localparam int PHASE_BEATS  = 150;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_PAD    = 20;
  localparam int SHOWN_ERRORS = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // block inputs, all known from time zero
  logic                    cfg_we = 1'b0;
  logic [7:0]              cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic [7:0]              tooth_fill_count = '0;
  logic [7:0]              time_fill_count = '0;
  logic                    calc_enable = 1'b0;
  logic                    last_period_valid = 1'b0;
  logic                    first_calc = 1'b0;
  logic signed [15:0]      raw_speed = '0;
  logic signed [15:0]      low_speed_threshold = '0;
  logic [31:0]             latest_period = '0;
  logic [31:0]             previous_period = '0;
  logic                    forward_rotation = 1'b0;
  logic                    out_stall = 1'b0;

  // block outputs
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic signed [SPD_W-1:0] period_speed_o;
  logic                    cell_valid_o;
  logic signed [SPD_W-1:0] corrected_speed_o;
  logic                    corrected_valid_o;

  // predictor state: its own copy of the latch and the threshold
  logic       latch_model = 1'b0;
  logic [7:0] thr_model = '0;

  speed_beat_t speed_due_q[$];
  dir_row_t    dir_tab[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  int n_err = 0;
  int n_beats = 0;
  int n_checked = 0;
  int n_cell = 0;
  int n_stalled_in = 0;

  tooth_period_speed_estimator u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we),
    .cfg_wdata_i          (cfg_wdata),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall_o),
    .tooth_fill_count_i   (tooth_fill_count),
    .time_fill_count_i    (time_fill_count),
    .calc_enable_i        (calc_enable),
    .last_period_valid_i  (last_period_valid),
    .first_calc_i         (first_calc),
    .raw_speed_i          (raw_speed),
    .low_speed_threshold_i(low_speed_threshold),
    .latest_period_i      (latest_period),
    .previous_period_i    (previous_period),
    .forward_rotation_i   (forward_rotation),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall),
    .period_speed_o       (period_speed_o),
    .cell_valid_o         (cell_valid_o),
    .corrected_speed_o    (corrected_speed_o),
    .corrected_valid_o    (corrected_valid_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // speed estimate for one beat; updates the latch copy as the block would
  function automatic speed_beat_t estimate_speed(input tooth_beat_t b);
    logic [31:0] pa, pb, pmin;
    logic        qual, cell_ok, enough;
    int          ps, sel;
    speed_beat_t r;
    pa = (b.p_latest > PERIOD_CAP) ? PERIOD_CAP : b.p_latest;
    pb = (b.p_prev > PERIOD_CAP) ? PERIOD_CAP : b.p_prev;
    pmin = (pa < pb) ? pa : pb;
    if (pmin < PERIOD_FLOOR) pmin = PERIOD_FLOOR;
    // qualified raw speed: enough teeth, enabled, period valid, not the first pass
    qual = (b.tooth_fill > thr_model) && b.calc_en && b.period_ok && !b.first;
    // clearing takes priority over setting
    if (qual && (b.raw < b.low_thd)) begin
      latch_model = 1'b0;
    end else if (b.first) begin
      latch_model = 1'b1;
    end
    cell_ok = qual && latch_model;
    ps = int'(SPEED_DIVIDEND / pmin);
    if (!b.fwd) ps = -ps;
    if (ps < SPEED_FLOOR) ps = SPEED_FLOOR;
    enough = (b.time_fill >= MIN_PERIODS);
    sel = cell_ok ? int'(b.raw) : (enough ? ps : 0);
    if (sel < SPEED_FLOOR) sel = SPEED_FLOOR;
    if (sel > SPEED_CEIL) sel = SPEED_CEIL;
    r.period_speed    = SPD_W'(ps);
    r.cell_valid      = cell_ok;
    r.corrected_speed = SPD_W'(sel);
    r.corrected_valid = cell_ok || enough;
    return r;
  endfunction

  function automatic dir_row_t mk_row(input int tf, input int ti,
                                      input int ce, input int pv, input int fc,
                                      input int rs, input int ls,
                                      input logic [31:0] pl, input logic [31:0] pp,
                                      input int fw, input int typed,
                                      input int ps, input int cvl,
                                      input int cs, input int cov);
    dir_row_t d;
    d.beat.tooth_fill = 8'(tf);
    d.beat.time_fill  = 8'(ti);
    d.beat.calc_en    = 1'(ce);
    d.beat.period_ok  = 1'(pv);
    d.beat.first      = 1'(fc);
    d.beat.raw        = 16'(rs);
    d.beat.low_thd    = 16'(ls);
    d.beat.p_latest   = pl;
    d.beat.p_prev     = pp;
    d.beat.fwd        = 1'(fw);
    d.typed                = 1'(typed);
    d.want.period_speed    = SPD_W'(ps);
    d.want.cell_valid      = 1'(cvl);
    d.want.corrected_speed = SPD_W'(cs);
    d.want.corrected_valid = 1'(cov);
    return d;
  endfunction

  function automatic logic [31:0] rand_period();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(2000);
      2: return $urandom_range(500100);
      default: return $urandom_range(600000, 400000);
    endcase
  endfunction

  // mostly qualified beats with random content, so the latch gets set, held and
  // cleared; the rest is noise on the flags and fill counts
  function automatic tooth_beat_t rand_beat();
    tooth_beat_t b;
    b.first = ($urandom_range(99) < 8);
    if ($urandom_range(99) < 80) begin
      b.calc_en    = ($urandom_range(99) < 95);
      b.period_ok  = ($urandom_range(99) < 95);
      b.tooth_fill = (thr_model < 8'd255) ? 8'($urandom_range(255, int'(thr_model) + 1))
                                          : 8'($urandom_range(255));
    end else begin
      b.calc_en    = 1'($urandom_range(1));
      b.period_ok  = 1'($urandom_range(1));
      b.tooth_fill = 8'($urandom_range(255));
    end
    case ($urandom_range(3))
      0: b.raw = 16'($urandom);
      3: b.raw = 16'(int'($urandom_range(3000)) - 1500);
      default: b.raw = 16'(int'($urandom_range(1600)) - 600);
    endcase
    b.low_thd = ($urandom_range(99) < 20) ? 16'($urandom)
                                          : 16'(int'($urandom_range(600)) - 500);
    b.time_fill = ($urandom_range(99) < 70) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    b.p_latest  = rand_period();
    b.p_prev    = rand_period();
    b.fwd       = 1'($urandom_range(1));
    return b;
  endfunction

  task automatic report_err(input string what, input int want, input int got);
    n_err++;
    if (n_err <= SHOWN_ERRORS)
      $display("mismatch %s: expected %0d, got %0d (at %0t)", what, want, got, $realtime);
  endtask

  // offer one beat, wait for its accept, then queue what it should produce
  task automatic send_beat(input tooth_beat_t b, input logic typed, input speed_beat_t want);
    speed_beat_t est;
    // random sender gaps before the beat
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    tooth_fill_count    <= b.tooth_fill;
    time_fill_count     <= b.time_fill;
    calc_enable         <= b.calc_en;
    last_period_valid   <= b.period_ok;
    first_calc          <= b.first;
    raw_speed           <= b.raw;
    low_speed_threshold <= b.low_thd;
    latest_period       <= b.p_latest;
    previous_period     <= b.p_prev;
    forward_rotation    <= b.fwd;
    in_valid            <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) begin
      n_stalled_in++;
      @(posedge clk_i);
    end
    // the predictor runs on every beat so the latch copy stays in step
    est = estimate_speed(b);
    speed_due_q.push_back(typed ? want : est);
    n_beats++;
  endtask

  // let every pending result come out, then give the block time to settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (speed_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  // only called while the block is idle
  task automatic write_threshold(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    thr_model = v;
    @(posedge clk_i);
  endtask

  // receiver: random stall, plus a long hold-off on request to back up the block
  initial begin : receiver
    int k;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) begin
          out_stall <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk_i) begin : result_check
    speed_beat_t w;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (speed_due_q.size() == 0) begin
        report_err("result with nothing pending", 0, 1);
      end else begin
        w = speed_due_q.pop_front();
        n_checked++;
        if (cell_valid_o) n_cell++;
        if (period_speed_o !== w.period_speed)
          report_err("period_speed", int'(w.period_speed), int'(period_speed_o));
        if (cell_valid_o !== w.cell_valid)
          report_err("cell_valid", int'(w.cell_valid), int'(cell_valid_o));
        if (corrected_speed_o !== w.corrected_speed)
          report_err("corrected_speed", int'(w.corrected_speed), int'(corrected_speed_o));
        if (corrected_valid_o !== w.corrected_valid)
          report_err("corrected_valid", int'(w.corrected_valid), int'(corrected_valid_o));
      end
    end
  end

  // hard stop far beyond the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("tooth_period_speed_estimator_tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  thr_list [PHASES];
    speed_beat_t none;
    int          ph, i;
    none = '{default: '0};
    thr_list[0] = 8'd255;
    thr_list[1] = 8'd0;
    thr_list[2] = 8'($urandom_range(255));
    thr_list[3] = 8'd1;
    thr_list[4] = 8'($urandom_range(255));
    thr_list[5] = 8'd254;

    // directed rows, threshold still at its reset value of zero
    // extremes with the latch still clear: expectations read straight off the rules
    dir_tab.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 32'd0, 32'd0, 0,
                             1, -500, 0, 0, 0));
    dir_tab.push_back(mk_row(0, 2, 0, 0, 0, 0, 0, 32'd0, 32'd0, 1,
                             1, 1000, 0, 1000, 1));
    dir_tab.push_back(mk_row(0, 255, 1, 1, 0, 32767, 0, '1, '1, 1,
                             1, 2, 0, 2, 1));
    dir_tab.push_back(mk_row(0, 1, 1, 1, 0, -32768, 32767, '1, '1, 0,
                             1, -2, 0, 0, 0));
    dir_tab.push_back(mk_row(255, 255, 1, 1, 0, 100, 0, '1, '1, 1,
                             1, 2, 0, 2, 1));
    // period floor and cap edges
    dir_tab.push_back(mk_row(0, 2, 0, 0, 0, 0, 0, 32'd1000, 32'd999999, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(0, 2, 0, 0, 0, 0, 0, 32'd1001, 32'd1001, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(0, 3, 0, 0, 0, 0, 0, 32'd500001, 32'd500000, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(0, 2, 0, 0, 0, 0, 0, 32'd2000, 32'd999, 0, 0, 0, 0, 0, 0));
    // first pass sets the latch, then qualified raw speeds pass through, clamped
    dir_tab.push_back(mk_row(255, 0, 1, 1, 1, 0, 0, 32'd5000, 32'd6000, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(1, 0, 1, 1, 0, 700, -32768, 32'd5000, 32'd6000, 1,
                             0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(255, 0, 1, 1, 0, 32767, -32768, 32'd5000, 32'd6000, 0,
                             0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(255, 0, 1, 1, 0, -32768, -32768, 32'd5000, 32'd6000, 1,
                             0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(255, 2, 1, 1, 0, -501, -600, 32'd3000, 32'd3000, 1,
                             0, 0, 0, 0, 0));
    // fill count, calc enable or period valid alone disqualifies and leaves the latch alone
    dir_tab.push_back(mk_row(0, 2, 1, 1, 0, -100, 100, 32'd3000, 32'd4000, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(9, 2, 0, 1, 0, -100, 100, 32'd3000, 32'd4000, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(9, 2, 1, 0, 0, -100, 100, 32'd3000, 32'd4000, 1, 0, 0, 0, 0, 0));
    // qualified speed below the threshold clears the latch
    dir_tab.push_back(mk_row(9, 0, 1, 1, 0, -1, 0, 32'd3000, 32'd4000, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(9, 2, 1, 1, 0, 900, 0, 32'd3000, 32'd4000, 0, 0, 0, 0, 0, 0));
    // first pass with a raw speed below the threshold still sets the latch
    dir_tab.push_back(mk_row(9, 2, 1, 1, 1, -900, 900, 32'd3000, 32'd4000, 0,
                             0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(9, 2, 1, 1, 0, 1001, 1000, 32'd0, 32'd0, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(9, 2, 1, 1, 0, 999, 1000, 32'd0, 32'd0, 1, 0, 0, 0, 0, 0));

    // reset once
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
    drain_results();

    for (ph = 0; ph < PHASES; ph++) begin
      // light sender gaps with a busy receiver, then swapped, then no gaps at all
      case (ph / 2)
        0: begin send_idle_pct = 17; recv_idle_pct = 45; end
        1: begin send_idle_pct = 45; recv_idle_pct = 17; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_threshold(thr_list[ph]);
      // long receiver hold-off while beats keep coming
      if (ph == 1 || ph == 4) hold_req = 1'b1;
      for (i = 0; i < PHASE_BEATS; i++) send_beat(rand_beat(), 1'b0, none);
      drain_results();
    end

    if (speed_due_q.size() != 0) report_err("results never returned", 0, speed_due_q.size());
    $display("covered %0d beats over %0d threshold settings, %0d results checked",
             n_beats, PHASES + 1, n_checked);
    $display("%0d results with the cell valid, %0d cycles of input stall, %0d mismatches",
             n_cell, n_stalled_in, n_err);
    if (n_err == 0) begin
      $display("tooth_period_speed_estimator_tb: clean");
    end else begin
      $display("tooth_period_speed_estimator_tb: errors");
    end
    $finish;
  end

endmodule
